>>> hw/rtl/dfi_pkg.sv
// ----------------------------------------------------------------------------
// dfi_pkg
// Types, character codes and helpers shared by the decimal field reader.
// ----------------------------------------------------------------------------
package dfi_pkg;

   // one input item: a character of the field plus field framing
   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
      logic [7:0] field_width;
      logic [3:0] result_size;
   } req_type;

   // one result item
   typedef struct packed {
      logic signed [63:0] value;
      logic [1:0]         status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic take;   // accept one input item
      logic setup;  // compute the trailing zero count
      logic pad;    // one trailing zero step
      logic emit;   // load the result register and close the field
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pad_done;
   } sts_type;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERLONG = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_BLANK = 8'd32;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;

   // destination sizes in bytes
   localparam logic [3:0] SIZE_BYTE = 4'd1;
   localparam logic [3:0] SIZE_HALF = 4'd2;
   localparam logic [3:0] SIZE_WORD = 4'd4;
   localparam logic [3:0] SIZE_LONG = 4'd8;

   // default field widths
   localparam logic [7:0] WIDTH_SHORT = 8'd7;
   localparam logic [7:0] WIDTH_MID   = 8'd12;
   localparam logic [7:0] WIDTH_LONG  = 8'd21;

   // default width for a zero field width, chosen by destination size
   function automatic logic [7:0] default_width(input logic [3:0] rs);
      logic [7:0] w;
      if (rs < SIZE_WORD) begin
         w = WIDTH_SHORT;
      end else if (rs < SIZE_LONG) begin
         w = WIDTH_MID;
      end else begin
         w = WIDTH_LONG;
      end
      return w;
   endfunction

   // blank, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_white(input logic [7:0] c);
      return (c == CHAR_BLANK) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

>>> hw/rtl/dfi_ctrl.sv
// ----------------------------------------------------------------------------
// dfi_ctrl
// Sequencer for the decimal field reader: character intake, trailing zero
// padding loop, and result hand-off into the output register.
// ----------------------------------------------------------------------------
module dfi_ctrl
   import dfi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SETUP,
      ST_PAD,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // commands decoded from state
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_RUN);
      case (state_ff)
         ST_RUN:   cmd.take  = req_valid;
         ST_SETUP: cmd.setup = 1'b1;
         ST_PAD:   cmd.pad   = !sts.pad_done;
         ST_EMIT:  cmd.emit  = out_free;
         default:  cmd       = '0;
      endcase
   end

   // next state and result valid
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (req_valid && req_last) state_in = ST_SETUP;
         end
         ST_SETUP: state_in = ST_PAD;
         ST_PAD: begin
            if (sts.pad_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_RUN;
         end
         default: state_in = ST_RUN;
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // the item after a last item waits for the result to be formed
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("item taken right after the last item of a field");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && rsp_valid_ff && rsp_stall))
      else $error("result register loaded while its result is stalled");

   // a loaded result is presented in the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

>>> hw/rtl/dfi_datapath.sv
// ----------------------------------------------------------------------------
// dfi_datapath
// Field state, digit accumulator, padding counter, size fit and the
// result register of the decimal field reader.
// ----------------------------------------------------------------------------
module dfi_datapath
   import dfi_pkg::*;
#(
   parameter int MAX_FIELD = 84
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req,
   input  logic    cfg_write,
   input  logic    cfg_data,
   output rsp_type rsp
);

   localparam logic [7:0] PARSE_LIMIT = 8'(MAX_FIELD - 1);

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_HALT
   } phase_type;

   logic        blank_zero_ff;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic        stopped_ff, stopped_in;
   logic [1:0]  err_ff, err_in;
   logic [7:0]  width_ff, width_in;
   logic [3:0]  size_ff, size_in;
   logic [7:0]  pad_ff, pad_in;
   rsp_type     out_ff;

   logic [7:0]  width_eff, limit_eff, limit_cur, parsed;
   logic [3:0]  size_eff;
   logic [63:0] acc_ten, digit, x_sign, x_fit;
   logic        is_digit;

   // width and size latch on the first item of a field
   always_comb begin
      if (width_ff == '0) begin
         width_eff = (req.field_width == '0) ? default_width(req.result_size)
                                             : req.field_width;
         size_eff  = req.result_size;
      end else begin
         width_eff = width_ff;
         size_eff  = size_ff;
      end
      limit_eff = (width_eff < PARSE_LIMIT) ? width_eff : PARSE_LIMIT;
      limit_cur = (width_ff < PARSE_LIMIT) ? width_ff : PARSE_LIMIT;
      parsed    = (count_ff > limit_cur) ? limit_cur : count_ff;
   end

   // times ten by shift and add
   assign acc_ten  = (acc_ff << 3) + (acc_ff << 1);
   assign is_digit = (req.ch >= CHAR_ZERO) && (req.ch <= CHAR_NINE);
   assign digit    = {60'd0, 4'(req.ch - CHAR_ZERO)};

   // character step, padding step and field close
   always_comb begin
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      err_in     = err_ff;
      width_in   = width_ff;
      size_in    = size_ff;
      pad_in     = pad_ff;
      if (cmd.take) begin
         width_in = width_eff;
         size_in  = size_eff;
         if (!stopped_ff) begin
            if (req.has_char) begin
               if (count_ff < limit_eff) begin
                  // parsed part of the field
                  if (phase_ff == PH_LEAD && req.ch == CHAR_BLANK) begin
                     phase_in = PH_LEAD;
                  end else if (phase_ff == PH_LEAD &&
                               (req.ch == CHAR_MINUS || req.ch == CHAR_PLUS)) begin
                     phase_in = PH_DIGITS;
                     neg_in   = (req.ch == CHAR_MINUS);
                  end else if (phase_ff == PH_LEAD || phase_ff == PH_DIGITS) begin
                     phase_in = PH_DIGITS;
                     if (is_digit) begin
                        acc_in = acc_ten + digit;
                     end else if (req.ch == CHAR_BLANK) begin
                        if (blank_zero_ff) acc_in = acc_ten;
                     end else begin
                        phase_in = PH_HALT;
                        if (err_ff == STATUS_OK) err_in = STATUS_INVALID;
                     end
                  end
               end else if (count_ff < width_eff) begin
                  // past the parse limit only white space is allowed
                  if (!is_white(req.ch)) err_in = STATUS_OVERLONG;
               end
               if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
            end else begin
               stopped_in = 1'b1;
            end
         end
      end
      if (cmd.setup) begin
         if (blank_zero_ff && phase_ff != PH_HALT && parsed < width_ff) begin
            pad_in = width_ff - parsed;
         end else begin
            pad_in = '0;
         end
      end
      if (cmd.pad) begin
         acc_in = acc_ten;
         pad_in = pad_ff - 8'd1;
      end
      if (cmd.emit) begin
         acc_in     = '0;
         neg_in     = 1'b0;
         phase_in   = PH_LEAD;
         count_in   = '0;
         stopped_in = 1'b0;
         err_in     = STATUS_OK;
         width_in   = '0;
         size_in    = '0;
      end
   end

   // sign and fit to destination size
   always_comb begin
      x_sign = neg_ff ? (64'd0 - acc_ff) : acc_ff;
      case (size_ff)
         SIZE_BYTE: x_fit = {{56{x_sign[7]}}, x_sign[7:0]};
         SIZE_HALF: x_fit = {{48{x_sign[15]}}, x_sign[15:0]};
         SIZE_LONG: x_fit = x_sign;
         default:   x_fit = {{32{x_sign[31]}}, x_sign[31:0]};
      endcase
   end

   // field state
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_zero_ff <= 1'b0;
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         phase_ff      <= PH_LEAD;
         count_ff      <= '0;
         stopped_ff    <= 1'b0;
         err_ff        <= STATUS_OK;
         width_ff      <= '0;
         size_ff       <= '0;
         pad_ff        <= '0;
      end else begin
         if (cfg_write) blank_zero_ff <= cfg_data;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         err_ff     <= err_in;
         width_ff   <= width_in;
         size_ff    <= size_in;
         pad_ff     <= pad_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff.value  <= (err_ff == STATUS_OVERLONG) ? '0 : $signed(x_fit);
         out_ff.status <= err_ff;
      end
   end

   assign rsp          = out_ff;
   assign sts.pad_done = (pad_ff == '0);

endmodule

>>> hw/rtl/decimal_field_to_integer_core.sv
// ----------------------------------------------------------------------------
// decimal_field_to_integer_core
// Fixed-width decimal integer field reader, one character per item.
// ----------------------------------------------------------------------------
// Usage: send the characters of one field on the req_ channel, one per item,
// with field_width and result_size on the first item and last set on the
// final item. An item with has_char low ends the field early. Each field
// gives one result on the rsp_ channel: the value cut to the destination
// size and sign-extended, and a status code.
// Throughput: one character per cycle while a field is open. After the
// last item the sequencer stalls the input through a setup step, one step
// per trailing zero digit in blank-as-zero mode (one multiply by ten a
// cycle) and an emit step, until the result is in the output register.
// The output register lets the next field's characters enter while a
// result is stalled; only the next result waits for it to be taken.
// csr_ writes set the blank-as-zero mode and are always ready; write it
// only between fields. Reset clears the mode, the open field and any
// pending result.
// ----------------------------------------------------------------------------
module decimal_field_to_integer_core
   import dfi_pkg::*;
#(
   parameter int MAX_FIELD = 84
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   dfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // field state and arithmetic
   dfi_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req       (req_payload),
      .cfg_write (csr_valid && csr_ready),
      .cfg_data  (csr_wdata),
      .rsp       (rsp_payload)
   );

endmodule

>>> tb/decimal_field_to_integer_core_tb.sv
// ----------------------------------------------------------------------------
// decimal_field_to_integer_core_tb
// Self-checking bench for the fixed-width decimal field reader: fields are
// sent one character per item, a local predictor of the parser computes each
// field's value and status, and every result is compared in order against it.
// ----------------------------------------------------------------------------
module decimal_field_to_integer_core_tb;
   import dfi_pkg::*;

   localparam int MAX_FIELD       = 84;
   localparam int CLOCK_PERIOD    = 12;
   localparam int TIMEOUT_CYCLES  = 800000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 200;

   // characters used by the stimulus beyond those in the package
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TOP   = 8'hFF;
   localparam logic [7:0] CHAR_COMMA = 8'd44;

   typedef byte unsigned char_q_type[$];
   typedef enum logic [1:0] {END_ON_CHAR, END_ON_TERM, END_TERM_THEN_JUNK} field_end_type;
   typedef enum logic [1:0] {SCAN_LEAD, SCAN_DIGITS, SCAN_HALT} scan_phase_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_wdata;

   decimal_field_to_integer_core #(
      .MAX_FIELD(MAX_FIELD)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // parser state mirrored by the predictor
   bit             blank_zero;
   logic [63:0]    acc;
   bit             neg;
   scan_phase_type phase;
   logic [7:0]     char_count;
   bit             stopped;
   logic [1:0]     err_code;
   logic [7:0]     width_latched;
   logic [3:0]     size_latched;

   rsp_type expected_results[$];
   int      failures;
   int      items_sent;
   bit      gaps_enabled;
   int      burst_left;
   bit      hold_off_pending;

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void clear_field();
      acc           = '0;
      neg           = 1'b0;
      phase         = SCAN_LEAD;
      char_count    = '0;
      stopped       = 1'b0;
      err_code      = STATUS_OK;
      width_latched = '0;
      size_latched  = '0;
   endfunction

   // advance the parser by one item, queue the field result on its last item
   function automatic void absorb_item(input req_type item);
      logic [7:0]  lim;
      logic [7:0]  c;
      logic [63:0] x;
      int          parsed;
      int          k;
      bit          consumed;
      rsp_type     res;
      if (width_latched == 0) begin
         if (item.field_width != 0) begin
            width_latched = item.field_width;
         end else if (item.result_size < SIZE_WORD) begin
            width_latched = WIDTH_SHORT;
         end else if (item.result_size < SIZE_LONG) begin
            width_latched = WIDTH_MID;
         end else begin
            width_latched = WIDTH_LONG;
         end
         size_latched = item.result_size;
      end
      lim = (width_latched < MAX_FIELD - 1) ? width_latched : 8'(MAX_FIELD - 1);
      if (!stopped) begin
         if (item.has_char) begin
            c = item.ch;
            if (char_count < lim) begin
               consumed = 1'b0;
               if (phase == SCAN_LEAD) begin
                  if (c == CHAR_BLANK) begin
                     consumed = 1'b1;
                  end else begin
                     phase = SCAN_DIGITS;
                     if (c == CHAR_MINUS) begin
                        neg      = 1'b1;
                        consumed = 1'b1;
                     end else if (c == CHAR_PLUS) begin
                        consumed = 1'b1;
                     end
                  end
               end
               if (!consumed && phase == SCAN_DIGITS) begin
                  if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                     acc = acc * 10 + 64'(c - CHAR_ZERO);
                  end else if (c == CHAR_BLANK) begin
                     if (blank_zero) acc = acc * 10;
                  end else begin
                     phase = SCAN_HALT;
                     if (err_code == STATUS_OK) err_code = STATUS_INVALID;
                  end
               end
            end else if (char_count < width_latched) begin
               // past the parse limit only white space is allowed
               if (!(c == CHAR_BLANK || (c >= CHAR_TAB && c <= CHAR_CR)))
                  err_code = STATUS_OVERLONG;
            end
            if (char_count != 8'hFF) char_count++;
         end else begin
            stopped = 1'b1;
         end
      end
      if (item.last) begin
         x      = acc;
         parsed = int'((char_count > lim) ? lim : char_count);
         // trailing zero padding in blank-as-zero mode
         if (blank_zero && phase != SCAN_HALT) begin
            for (k = parsed; k < width_latched; k++) x = x * 10;
         end
         if (neg) x = -x;
         case (size_latched)
            SIZE_BYTE: x = {{56{x[7]}}, x[7:0]};
            SIZE_HALF: x = {{48{x[15]}}, x[15:0]};
            SIZE_LONG: x = x;
            default:   x = {{32{x[31]}}, x[31:0]};
         endcase
         if (err_code == STATUS_OVERLONG) x = '0;
         res.value  = x;
         res.status = err_code;
         expected_results.push_back(res);
         clear_field();
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: value %0d status %0d",
                   rsp_payload.value, rsp_payload.status);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.value !== want.value) begin
               $error("value mismatch: expected %0d, actual %0d",
                      want.value, rsp_payload.value);
               failures++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      want.status, rsp_payload.status);
               failures++;
            end
         end
      end
   end

   // receiver stall pattern with an occasional long hold-off
   initial begin
      int hold_left;
      int mode_left;
      int stall_mode;
      hold_left  = 0;
      mode_left  = 0;
      stall_mode = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(10, 60);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // offer one item until taken, then pace the sender in bursts
   task automatic send_item(input req_type item);
      int gap;
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      absorb_item(item);
      items_sent++;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   // send one field; only the first item's width and size are meaningful
   task automatic send_field(input char_q_type text, input logic [7:0] fw,
                             input logic [3:0] rs, input field_end_type how);
      req_type item;
      int      n;
      int      i;
      int      junk;
      n = text.size();
      for (i = 0; i < n; i++) begin
         item.ch          = text[i];
         item.has_char    = 1'b1;
         item.last        = (how == END_ON_CHAR) && (i == n - 1);
         item.field_width = (i == 0) ? fw : 8'($urandom);
         item.result_size = (i == 0) ? rs : 4'($urandom_range(1, 8));
         send_item(item);
      end
      if (how != END_ON_CHAR || n == 0) begin
         item.ch          = 8'($urandom);
         item.has_char    = 1'b0;
         item.last        = (how != END_TERM_THEN_JUNK);
         item.field_width = (n == 0) ? fw : 8'($urandom);
         item.result_size = (n == 0) ? rs : 4'($urandom_range(1, 8));
         send_item(item);
         if (how == END_TERM_THEN_JUNK) begin
            junk = $urandom_range(1, 3);
            for (i = 0; i < junk; i++) begin
               item.ch          = 8'($urandom);
               item.has_char    = 1'($urandom_range(0, 1));
               item.last        = (i == junk - 1);
               item.field_width = 8'($urandom);
               item.result_size = 4'($urandom_range(1, 8));
               send_item(item);
            end
         end
      end
   endtask

   function automatic char_q_type to_text(input string s);
      char_q_type q;
      int         i;
      for (i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // drop valid and wait until every result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_blank_mode(input bit mode);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      blank_zero  = mode;
   endtask

   // signs, size extremes, blanks, invalid bytes, early end, padding
   task automatic test_directed();
      char_q_type t;
      gaps_enabled = 1'b0;
      send_field(to_text("-128"), 8'd4, SIZE_BYTE, END_ON_CHAR);
      send_field(to_text(" 5 0"), 8'd4, SIZE_HALF, END_ON_CHAR);
      send_field(to_text("9x"), 8'd2, SIZE_WORD, END_ON_CHAR);
      t = '{CHAR_NUL};
      send_field(t, 8'd1, SIZE_LONG, END_ON_CHAR);
      t = '{CHAR_TOP};
      send_field(t, 8'd3, 4'd3, END_ON_CHAR);
      t = '{};
      send_field(t, 8'd0, SIZE_LONG, END_ON_TERM);
      write_blank_mode(1'b1);
      send_field(to_text("1 2"), 8'd5, 4'd3, END_ON_CHAR);
      send_field(to_text("7"), 8'd0, SIZE_LONG, END_ON_TERM);
      send_field(to_text("+"), 8'd0, SIZE_BYTE, END_TERM_THEN_JUNK);
      wait_idle();
   endtask

   // mostly well-formed numbers with random content, plus noise
   task automatic send_random_field();
      char_q_type    text;
      logic [7:0]    fw;
      logic [7:0]    w;
      logic [3:0]    rs;
      int            kind;
      int            n;
      int            i;
      int            pick;
      field_end_type how;
      rs = 4'($urandom_range(1, 8));
      fw = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 20));
      if (fw != 0) w = fw;
      else if (rs < SIZE_WORD) w = WIDTH_SHORT;
      else if (rs < SIZE_LONG) w = WIDTH_MID;
      else w = WIDTH_LONG;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
         repeat ($urandom_range(0, 2)) text.push_back(CHAR_BLANK);
         case ($urandom_range(0, 2))
            0:       text.push_back(CHAR_MINUS);
            1:       text.push_back(CHAR_PLUS);
            default: ;
         endcase
         n = $urandom_range(1, w);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) text.push_back(CHAR_BLANK);
            else text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         end
         // one stray byte inside the number
         if (kind == 7) text.insert($urandom_range(0, text.size() - 1), 8'($urandom));
      end else if (kind == 8) begin
         n = $urandom_range(1, w + 2);
         for (i = 0; i < n; i++) text.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, w)) text.push_back(CHAR_BLANK);
      end
      pick = $urandom_range(0, 5);
      if (pick == 0) how = END_ON_TERM;
      else if (pick == 1) how = END_TERM_THEN_JUNK;
      else how = END_ON_CHAR;
      send_field(text, fw, rs, how);
   endtask

   task automatic test_random_fields(input int target);
      int start;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(0, 7) == 0) gaps_enabled = ~gaps_enabled;
         send_random_field();
      end
      wait_idle();
   endtask

   // widths just past and far past the parse limit
   task automatic test_long_fields();
      int         widths[2];
      char_q_type text;
      int         i;
      int         w;
      widths = '{MAX_FIELD, 200};
      gaps_enabled = 1'b1;
      foreach (widths[j]) begin
         w = widths[j];
         text = '{};
         if ($urandom_range(0, 1) == 1) text.push_back(CHAR_MINUS);
         repeat ($urandom_range(1, 12)) text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         while (text.size() < MAX_FIELD - 1) text.push_back(CHAR_BLANK);
         // white space past the limit, up to the width or a few positions
         while (text.size() < w && text.size() < MAX_FIELD + 4) begin
            if ($urandom_range(0, 1) == 1) text.push_back(CHAR_BLANK);
            else text.push_back(8'(CHAR_TAB + $urandom_range(0, 4)));
         end
         // non-blank text past the limit
         if (w > MAX_FIELD - 1 && $urandom_range(0, 1) == 1)
            text[$urandom_range(MAX_FIELD - 1, text.size() - 1)] =
               8'(CHAR_ZERO + $urandom_range(0, 9));
         // an invalid character ahead of it
         if ($urandom_range(0, 2) == 0) text[1] = CHAR_COMMA;
         // characters beyond the width are ignored
         if (text.size() == w) begin
            for (i = 0; i < 4; i++) text.push_back(8'($urandom));
         end
         send_field(text, 8'(w), 4'($urandom_range(1, 8)), END_ON_CHAR);
      end
      wait_idle();
   endtask

   // receiver holds off while fields keep coming, so the input backs up
   task automatic test_backpressure();
      char_q_type text;
      int         i;
      gaps_enabled     = 1'b0;
      hold_off_pending = 1'b1;
      for (i = 0; i < 8; i++) begin
         text = '{};
         repeat ($urandom_range(1, 3)) text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         send_field(text, 8'd3, SIZE_HALF, END_ON_CHAR);
      end
      wait_idle();
   endtask

   // main sequence
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_valid        = 1'b0;
      csr_wdata        = 1'b0;
      failures         = 0;
      items_sent       = 0;
      gaps_enabled     = 1'b0;
      burst_left       = 0;
      hold_off_pending = 1'b0;
      blank_zero       = 1'b0;
      clear_field();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      write_blank_mode(1'b0);
      test_random_fields(80);
      write_blank_mode(1'b1);
      test_random_fields(80);
      test_long_fields();
      test_backpressure();
      write_blank_mode(1'b0);
      test_backpressure();
      test_random_fields(20);

      wait_idle();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/dfi_pkg.sv
hw/rtl/dfi_ctrl.sv
hw/rtl/dfi_datapath.sv
hw/rtl/decimal_field_to_integer_core.sv
tb/decimal_field_to_integer_core_tb.sv
